// File: rtl/sph_cubic_spline_kernel_core_assert.svh
// Assertion macros shared by the checker of the cubic spline kernel core.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SPH_CUBIC_SPLINE_KERNEL_CORE_ASSERT_SVH
`define SPH_CUBIC_SPLINE_KERNEL_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SPHK_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sphk assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SPHK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sphk assertion failed");

`endif

// File: rtl/sphk_pkg.sv
// Shared constants and types of the cubic spline kernel core.
// No dependencies; imported by the square root, divider, evaluation and core modules.
package sphk_pkg;

    localparam int unsigned DEF_FRAC_BITS = 16;
    localparam int unsigned COORD_W       = 32;
    localparam int unsigned AD_W          = COORD_W + 1;
    localparam int unsigned SUM_W         = 2 * AD_W;
    localparam int unsigned LEN_W         = 34;
    localparam int unsigned CFG_W         = 32;
    localparam int unsigned CFG_IDX_W     = 8;
    localparam int unsigned KV_W          = 36;

    localparam logic [CFG_IDX_W-1:0] REG_Q_SCALE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFACTOR = 8'd1;

    // Polynomial coefficients of the kernel and its derivative.
    localparam int unsigned POLY_B_SHIFT = 2;   // times four
    localparam int unsigned GRAD_A_MUL   = 3;
    localparam int unsigned GRAD_B_MUL   = 12;

    typedef struct packed {
        logic       coinc;
        logic [2:0] neg;
    } t_side;

    typedef struct packed {
        logic sat;
        logic coinc;
        logic beyond;
    } t_flags;

endpackage

// File: rtl/sphk_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on sphk_pkg; carries an opaque side payload alongside.
module sphk_sqrt #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [sphk_pkg::SUM_W-1:0]  i_sum,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_vld,
    output logic [sphk_pkg::LEN_W-1:0]  o_len,
    output logic [SIDE_W-1:0]           o_side
);
    import sphk_pkg::*;

    localparam int unsigned T_W = 2 * LEN_W + 2;

    logic             r_vld  [LEN_W];
    logic [SUM_W-1:0] r_rem  [LEN_W];
    logic [LEN_W-1:0] r_root [LEN_W];
    logic [SIDE_W-1:0] r_side [LEN_W];

    for (genvar k = 0; k < LEN_W; k++) begin : g_stg
        localparam int unsigned BIT = LEN_W - 1 - k;
        logic              w_vld_in;
        logic [SUM_W-1:0]  w_rem_in;
        logic [LEN_W-1:0]  w_root_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [T_W-1:0]    w_trial;
        logic              w_take;

        if (k == 0) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_rem_in  = i_sum;
            assign w_root_in = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_side_in = r_side[k-1];
        end

        // Root bits so far sit above BIT, so the OR equals 2*root*2^BIT + 4^BIT.
        assign w_trial = (T_W'(w_root_in) << (BIT + 1)) | (T_W'(1) << (2 * BIT));
        assign w_take  = T_W'(w_rem_in) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_take ? w_rem_in - SUM_W'(w_trial) : w_rem_in;
                r_root[k] <= w_take ? (w_root_in | (LEN_W'(1) << BIT)) : w_root_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_vld  = r_vld[LEN_W-1];
    assign o_len  = r_root[LEN_W-1];
    assign o_side = r_side[LEN_W-1];

endmodule

// File: rtl/sphk_div.sv
// Pipelined restoring divider, three lanes, forming (|d| << F) / length.
// Depends on sphk_pkg; one quotient bit per register stage.
module sphk_div #(
    parameter int unsigned FRAC_BITS = sphk_pkg::DEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  logic [sphk_pkg::LEN_W-1:0]           i_len,
    input  logic [2:0][sphk_pkg::AD_W-1:0]       i_ad,
    input  sphk_pkg::t_side                      i_side,
    output logic                                 o_vld,
    output logic [sphk_pkg::LEN_W-1:0]           o_len,
    output logic [2:0][FRAC_BITS:0]              o_u,
    output sphk_pkg::t_side                      o_side
);
    import sphk_pkg::*;

    localparam int unsigned NSTG = FRAC_BITS + 1;
    localparam int unsigned U_W  = FRAC_BITS + 1;
    localparam int unsigned CW   = LEN_W + FRAC_BITS;

    logic                    r_vld  [NSTG];
    logic [LEN_W-1:0]        r_len  [NSTG];
    logic [2:0][CW-1:0]      r_rem  [NSTG];
    logic [2:0][U_W-1:0]     r_quo  [NSTG];
    t_side                   r_side [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        localparam int unsigned J = NSTG - 1 - k;
        logic                w_vld_in;
        logic [LEN_W-1:0]    w_len_in;
        logic [2:0][CW-1:0]  w_rem_in;
        logic [2:0][U_W-1:0] w_quo_in;
        t_side               w_side_in;
        logic [2:0][CW-1:0]  w_rem_nx;
        logic [2:0][U_W-1:0] w_quo_nx;

        if (k == 0) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_len_in  = i_len;
            assign w_side_in = i_side;
            assign w_quo_in  = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign w_rem_in[l] = CW'(i_ad[l]) << FRAC_BITS;
            end
        end else begin : g_next
            assign w_vld_in  = r_vld[k-1];
            assign w_len_in  = r_len[k-1];
            assign w_side_in = r_side[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_rem_in  = r_rem[k-1];
        end

        always_comb begin
            logic [CW-1:0] dv;
            dv = CW'(w_len_in) << J;
            for (int l = 0; l < 3; l++) begin
                if (w_rem_in[l] >= dv) begin
                    w_rem_nx[l] = w_rem_in[l] - dv;
                    w_quo_nx[l] = w_quo_in[l] | (U_W'(1) << J);
                end else begin
                    w_rem_nx[l] = w_rem_in[l];
                    w_quo_nx[l] = w_quo_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[k]  <= w_len_in;
                r_rem[k]  <= w_rem_nx;
                r_quo[k]  <= w_quo_nx;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_len  = r_len[NSTG-1];
    assign o_u    = r_quo[NSTG-1];
    assign o_side = r_side[NSTG-1];

endmodule

// File: rtl/sphk_eval.sv
// Kernel evaluation pipeline: q, the piecewise cubic, value and gradient.
// Depends on sphk_pkg; eight register stages, the last is the output register.
module sphk_eval #(
    parameter int unsigned FRAC_BITS = sphk_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [sphk_pkg::LEN_W-1:0]     i_len,
    input  logic [2:0][FRAC_BITS:0]        i_u,
    input  sphk_pkg::t_side                i_side,
    input  logic [sphk_pkg::CFG_W-1:0]     i_q_scale,
    input  logic [sphk_pkg::CFG_W-1:0]     i_prefactor,
    output logic                           o_vld,
    output logic [31:0]                    o_kv,
    output logic [2:0][31:0]               o_grad,
    output sphk_pkg::t_flags               o_flags
);
    import sphk_pkg::*;

    localparam int unsigned F     = FRAC_BITS;
    localparam int unsigned U_W   = F + 1;
    localparam int unsigned Q_W   = F + 1;
    localparam int unsigned QP_W  = LEN_W + CFG_W;
    localparam int unsigned A_W   = F + 2;
    localparam int unsigned B_W   = F + 1;
    localparam int unsigned A2_W  = F + 3;
    localparam int unsigned A3_W  = F + 4;
    localparam int unsigned G_W   = F + 6;
    localparam int unsigned GM_W  = F + 4;
    localparam int unsigned KP_W  = A3_W + CFG_W;
    localparam int unsigned MP_W  = KV_W + CFG_W;
    localparam int unsigned M_W   = MP_W - F;
    localparam int unsigned MH_W  = M_W - 32;
    localparam int unsigned PL_W  = 32 + U_W;
    localparam int unsigned PH_W  = MH_W + U_W;
    localparam int unsigned FW    = M_W + U_W;
    localparam int unsigned MAG_W = FW - F;

    // Stage 1: q = len * q_scale >> F
    logic [QP_W-1:0]     w_qp;
    logic                r1_vld, r1_beyond;
    logic [Q_W-1:0]      r1_q;
    logic [2:0][U_W-1:0] r1_u;
    t_side               r1_side;

    assign w_qp = QP_W'(i_len) * QP_W'(i_q_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_beyond <= |w_qp[QP_W-1:2*F+1];
            r1_q      <= w_qp[2*F:F];
            r1_u      <= i_u;
            r1_side   <= i_side;
        end
    end

    // Stage 2: a = 2 - q and b = 1 - q (zero when q >= 1), their squares
    logic [A_W-1:0]      w_a;
    logic [B_W-1:0]      w_b;
    logic [2*A_W-1:0]    w_aa;
    logic [2*B_W-1:0]    w_bb;
    logic                r2_vld, r2_beyond, r2_qnz;
    logic [A_W-1:0]      r2_a;
    logic [B_W-1:0]      r2_b;
    logic [A2_W-1:0]     r2_a2;
    logic [B_W-1:0]      r2_b2;
    logic [2:0][U_W-1:0] r2_u;
    t_side               r2_side;

    assign w_a  = (A_W'(1) << (F + 1)) - A_W'(r1_q);
    assign w_b  = r1_q[F] ? '0 : (B_W'(1) << F) - r1_q;
    assign w_aa = (2*A_W)'(w_a) * (2*A_W)'(w_a);
    assign w_bb = (2*B_W)'(w_b) * (2*B_W)'(w_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_beyond <= r1_beyond;
            r2_qnz    <= |r1_q;
            r2_a      <= w_a;
            r2_b      <= w_b;
            r2_a2     <= w_aa[F+A2_W-1:F];
            r2_b2     <= w_bb[2*F:F];
            r2_u      <= r1_u;
            r2_side   <= r1_side;
        end
    end

    // Stage 3: cubes
    logic [A2_W+A_W-1:0] w_aaa;
    logic [2*B_W-1:0]    w_bbb;
    logic                r3_vld, r3_beyond, r3_qnz;
    logic [A3_W-1:0]     r3_a3;
    logic [B_W-1:0]      r3_b3;
    logic [A2_W-1:0]     r3_a2;
    logic [B_W-1:0]      r3_b2;
    logic [2:0][U_W-1:0] r3_u;
    t_side               r3_side;

    assign w_aaa = (A2_W+A_W)'(r2_a2) * (A2_W+A_W)'(r2_a);
    assign w_bbb = (2*B_W)'(r2_b2) * (2*B_W)'(r2_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_beyond <= r2_beyond;
            r3_qnz    <= r2_qnz;
            r3_a3     <= w_aaa[F+A3_W-1:F];
            r3_b3     <= w_bbb[2*F:F];
            r3_a2     <= r2_a2;
            r3_b2     <= r2_b2;
            r3_u      <= r2_u;
            r3_side   <= r2_side;
        end
    end

    // Stage 4: polynomial (clamped at zero) and derivative factor g
    logic signed [G_W-1:0] w_pv, w_g;
    logic [G_W-1:0]        w_gabs;
    logic                  r4_vld, r4_beyond, r4_qnz, r4_gneg;
    logic [A3_W-1:0]       r4_poly;
    logic [GM_W-1:0]       r4_gm;
    logic [2:0][U_W-1:0]   r4_u;
    t_side                 r4_side;

    assign w_pv   = $signed(G_W'(r3_a3)) - $signed(G_W'(r3_b3) << POLY_B_SHIFT);
    assign w_g    = $signed(G_W'(r3_b2) * G_W'(GRAD_B_MUL))
                  - $signed(G_W'(r3_a2) * G_W'(GRAD_A_MUL));
    assign w_gabs = w_g[G_W-1] ? G_W'(-w_g) : G_W'(w_g);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_beyond <= r3_beyond;
            r4_qnz    <= r3_qnz;
            r4_poly   <= w_pv[G_W-1] ? '0 : w_pv[A3_W-1:0];
            r4_gneg   <= w_g[G_W-1];
            r4_gm     <= w_gabs[GM_W-1:0];
            r4_u      <= r3_u;
            r4_side   <= r3_side;
        end
    end

    // Stage 5: scale value and g by the prefactor
    logic [KP_W-1:0]     w_kvp, w_kp;
    logic                r5_vld, r5_beyond, r5_qnz, r5_gneg;
    logic [KV_W-1:0]     r5_kv, r5_k;
    logic [2:0][U_W-1:0] r5_u;
    t_side               r5_side;

    assign w_kvp = KP_W'(r4_poly) * KP_W'(i_prefactor);
    assign w_kp  = KP_W'(r4_gm) * KP_W'(i_prefactor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_beyond <= r4_beyond;
            r5_qnz    <= r4_qnz;
            r5_gneg   <= r4_gneg;
            r5_kv     <= w_kvp[KP_W-1:F];
            r5_k      <= w_kp[KP_W-1:F];
            r5_u      <= r4_u;
            r5_side   <= r4_side;
        end
    end

    // Stage 6: clip the value, scale g by q_scale
    logic [MP_W-1:0]     w_mp;
    logic                w_kvsat;
    logic                r6_vld, r6_beyond, r6_qnz, r6_gneg, r6_kvsat;
    logic [31:0]         r6_kv;
    logic [M_W-1:0]      r6_m;
    logic [2:0][U_W-1:0] r6_u;
    t_side               r6_side;

    assign w_mp    = MP_W'(r5_k) * MP_W'(i_q_scale);
    assign w_kvsat = |r5_kv[KV_W-1:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_beyond <= r5_beyond;
            r6_qnz    <= r5_qnz;
            r6_gneg   <= r5_gneg;
            r6_kvsat  <= w_kvsat;
            r6_kv     <= w_kvsat ? '1 : r5_kv[31:0];
            r6_m      <= w_mp[MP_W-1:F];
            r6_u      <= r5_u;
            r6_side   <= r5_side;
        end
    end

    // Stage 7: partial products of m times each unit direction component
    logic                 r7_vld, r7_beyond, r7_qnz, r7_gneg, r7_kvsat;
    logic [31:0]          r7_kv;
    logic [2:0][PL_W-1:0] r7_pl;
    logic [2:0][PH_W-1:0] r7_ph;
    t_side                r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_beyond <= r6_beyond;
            r7_qnz    <= r6_qnz;
            r7_gneg   <= r6_gneg;
            r7_kvsat  <= r6_kvsat;
            r7_kv     <= r6_kv;
            r7_side   <= r6_side;
            for (int l = 0; l < 3; l++) begin
                r7_pl[l] <= PL_W'(r6_m[31:0]) * PL_W'(r6_u[l]);
                r7_ph[l] <= PH_W'(r6_m[M_W-1:32]) * PH_W'(r6_u[l]);
            end
        end
    end

    // Stage 8: combine, sign, clip, and select the special cases
    logic [2:0][31:0] w_grad;
    logic [2:0]       w_gsat;

    always_comb begin
        logic [FW-1:0]    full;
        logic [MAG_W-1:0] mag;
        logic             neg;
        for (int l = 0; l < 3; l++) begin
            full = (FW'(r7_ph[l]) << 32) + FW'(r7_pl[l]);
            mag  = full[FW-1:F];
            neg  = r7_gneg ^ r7_side.neg[l];
            w_gsat[l] = 1'b0;
            if (mag == '0) begin
                w_grad[l] = '0;
            end else if (neg) begin
                if (mag > MAG_W'(64'h8000_0000)) begin
                    w_gsat[l] = 1'b1;
                    w_grad[l] = 32'h8000_0000;
                end else begin
                    w_grad[l] = 32'(0) - mag[31:0];
                end
            end else begin
                if (mag > MAG_W'(64'h7FFF_FFFF)) begin
                    w_gsat[l] = 1'b1;
                    w_grad[l] = 32'h7FFF_FFFF;
                end else begin
                    w_grad[l] = mag[31:0];
                end
            end
        end
    end

    logic             r8_vld;
    logic [31:0]      r8_kv;
    logic [2:0][31:0] r8_grad;
    t_flags           r8_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (i_en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_flags.beyond <= r7_beyond;
            r8_flags.coinc  <= r7_side.coinc;
            if (r7_beyond) begin
                r8_kv          <= '0;
                r8_grad        <= '0;
                r8_flags.sat   <= 1'b0;
            end else if (!r7_qnz) begin
                r8_kv          <= r7_kv;
                r8_grad        <= '0;
                r8_flags.sat   <= r7_kvsat;
            end else begin
                r8_kv          <= r7_kv;
                r8_grad        <= w_grad;
                r8_flags.sat   <= r7_kvsat | (|w_gsat);
            end
        end
    end

    assign o_vld   = r8_vld;
    assign o_kv    = r8_kv;
    assign o_grad  = r8_grad;
    assign o_flags = r8_flags;

endmodule

// File: rtl/sph_cubic_spline_kernel_core.sv
// Cubic spline SPH kernel core: for each request carrying two particle positions
// (signed Q16.16 by default) it returns the kernel value and its gradient vector,
// with flags for a pair beyond the support, coincident positions and clipping.
// The pipeline takes one request per clock while the output is not stalled and
// returns one result per request in order, through the input stages, the 34-stage
// square root, the one-bit-per-stage direction divider and the evaluation stages.
// Both configuration registers must be written only while the pipeline is empty.
module sph_cubic_spline_kernel_core #(
    parameter int unsigned FRAC_BITS = sphk_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request channel.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata from bit 0: first_x, first_y, first_z, second_x, second_y, second_z.
    input  logic [191:0]                      i_s_tdata,
    // Result channel.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata from bit 0: kernel_value, grad_x, grad_y, grad_z.
    output logic [127:0]                      o_m_tdata,
    // tuser from bit 0: beyond_support, coincident, saturated.
    output logic [2:0]                        o_m_tuser,
    // Configuration write channel: index 0 is q_scale, index 1 prefactor_value.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sphk_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [sphk_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import sphk_pkg::*;

    localparam logic [CFG_W-1:0] ONE_Q = CFG_W'(64'd1 << FRAC_BITS);
    localparam int unsigned SIDE_W = 3 * AD_W + $bits(t_side);

    // The whole pipeline moves together; it stalls only when a finished result
    // sits in the output register and the consumer does not take it.
    logic w_en;
    logic w_out_vld;

    assign w_en        = !w_out_vld || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    logic [CFG_W-1:0] r_q_scale, r_prefactor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_scale   <= ONE_Q;
            r_prefactor <= ONE_Q;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_Q_SCALE:   r_q_scale   <= i_cfg_wdata;
                REG_PREFACTOR: r_prefactor <= i_cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Stage 1: component differences, their magnitudes and signs.
    logic [2:0][COORD_W-1:0] w_p1, w_p2;
    logic [2:0][AD_W-1:0]    w_ad;
    logic [2:0]              w_neg;

    assign w_p1 = i_s_tdata[3*COORD_W-1:0];
    assign w_p2 = i_s_tdata[6*COORD_W-1:3*COORD_W];

    always_comb begin
        logic [AD_W-1:0] d;
        for (int l = 0; l < 3; l++) begin
            d        = {w_p1[l][COORD_W-1], w_p1[l]} - {w_p2[l][COORD_W-1], w_p2[l]};
            w_neg[l] = d[AD_W-1];
            w_ad[l]  = d[AD_W-1] ? AD_W'(0) - d : d;
        end
    end

    logic                 r1_vld;
    logic [2:0][AD_W-1:0] r1_ad;
    logic [2:0]           r1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ad  <= w_ad;
            r1_neg <= w_neg;
        end
    end

    // Stage 2: one squarer per axis.
    logic                  r2_vld;
    logic [2:0][SUM_W-1:0] r2_sq;
    logic [2:0][AD_W-1:0]  r2_ad;
    t_side                 r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r2_sq[l] <= SUM_W'(r1_ad[l]) * SUM_W'(r1_ad[l]);
            end
            r2_ad         <= r1_ad;
            r2_side.neg   <= r1_neg;
            r2_side.coinc <= (r1_ad == '0);
        end
    end

    // Stage 3: squared distance. Three squares of at most 2^64 fit 66 bits.
    logic                 r3_vld;
    logic [SUM_W-1:0]     r3_sum;
    logic [2:0][AD_W-1:0] r3_ad;
    t_side                r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sum  <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            r3_ad   <= r2_ad;
            r3_side <= r2_side;
        end
    end

    // Distance: floor of the square root, one bit per stage.
    logic                 w_sq_vld;
    logic [LEN_W-1:0]     w_sq_len;
    logic [SIDE_W-1:0]    w_sq_pack;
    logic [2:0][AD_W-1:0] w_sq_ad;
    t_side                w_sq_side;

    sphk_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r3_vld),
        .i_sum   (r3_sum),
        .i_side  ({r3_ad, r3_side}),
        .o_vld   (w_sq_vld),
        .o_len   (w_sq_len),
        .o_side  (w_sq_pack)
    );

    assign {w_sq_ad, w_sq_side} = w_sq_pack;

    // Unit direction |d| / length per axis, F fraction bits.
    logic                  w_dv_vld;
    logic [LEN_W-1:0]      w_dv_len;
    logic [2:0][FRAC_BITS:0] w_dv_u;
    t_side                 w_dv_side;

    sphk_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_len   (w_sq_len),
        .i_ad    (w_sq_ad),
        .i_side  (w_sq_side),
        .o_vld   (w_dv_vld),
        .o_len   (w_dv_len),
        .o_u     (w_dv_u),
        .o_side  (w_dv_side)
    );

    // Kernel polynomial, value, gradient and output register.
    logic [31:0]      w_kv;
    logic [2:0][31:0] w_grad;
    t_flags           w_flags;

    sphk_eval #(
        .FRAC_BITS (FRAC_BITS)
    ) u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (w_dv_vld),
        .i_len       (w_dv_len),
        .i_u         (w_dv_u),
        .i_side      (w_dv_side),
        .i_q_scale   (r_q_scale),
        .i_prefactor (r_prefactor),
        .o_vld       (w_out_vld),
        .o_kv        (w_kv),
        .o_grad      (w_grad),
        .o_flags     (w_flags)
    );

    assign o_m_tvalid = w_out_vld;
    assign o_m_tdata  = {w_grad[2], w_grad[1], w_grad[0], w_kv};
    assign o_m_tuser  = {w_flags.sat, w_flags.coinc, w_flags.beyond};

endmodule

// File: rtl/sphk_chk.sv
// Port-level checker for the cubic spline kernel core, with its bind.
// Depends on the assertion macros header.
`include "sph_cubic_spline_kernel_core_assert.svh"

module sphk_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tready,
    input logic         i_m_tvalid,
    input logic         i_m_tready,
    input logic [127:0] i_m_tdata,
    input logic [2:0]   i_m_tuser
);

    // A stalled result keeps its valid and its contents.
    `SPHK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))

    // An empty output register never back-pressures the request side.
    `SPHK_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_m_tvalid, i_s_tready)

    // Beyond the support, value and gradient are zero and nothing is clipped.
    `SPHK_ASSERT_NOW(a_beyond_zero, i_clk, i_rst_n, i_m_tvalid && i_m_tuser[0], (i_m_tdata == 128'd0) && !i_m_tuser[2])

    // Coincident positions give a zero gradient.
    `SPHK_ASSERT_NOW(a_coinc_grad, i_clk, i_rst_n, i_m_tvalid && i_m_tuser[1], i_m_tdata[127:32] == 96'd0)

endmodule

bind sph_cubic_spline_kernel_core sphk_chk u_sphk_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
